// ===== hdl/depth_pixel_to_world_point_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the depth back-projection block
// Shared property forms: a same-cycle implication and a fixed-delay response.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH

// Check that the consequent holds whenever the antecedent holds
`define DPW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds a fixed number of cycles after the antecedent
`define DPW_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
    else $error(msg);

`endif

// ===== hdl/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth back-projection package
// Field widths, camera intrinsics, divider constants and the item types.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // Field widths
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ROW_REG_W  = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned DIM_W      = 13;

  // Intrinsics, in tenths of a pixel, and depth scale
  localparam int unsigned TENTHS      = 10;
  localparam int unsigned DEPTH_PER_M = 5000;
  localparam int unsigned CX_TENTHS   = 3186;
  localparam int unsigned CY_TENTHS   = 2553;
  localparam int unsigned FX_TENTHS   = 5173;
  localparam int unsigned FY_TENTHS   = 5165;

  // Fraction bits of camera/world coordinates and of rotation coefficients
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned COEF_FRAC  = 14;

  // Axis slots (rotation rows and translations use the same order)
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned AXIS_X   = 0;
  localparam int unsigned AXIS_Y   = 1;
  localparam int unsigned AXIS_Z   = 2;

  // Back-projection datapath widths
  localparam int unsigned OFS_W   = 15;  // signed pixel offset in tenths
  localparam int unsigned AMAG_W  = 13;  // offset magnitude
  localparam int unsigned PW      = 29;  // offset magnitude times depth
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned TRIAL_W = PW + RECIP_W;
  localparam int unsigned QUO_W   = 21;
  localparam int unsigned NUM_W   = 46;
  localparam int unsigned CAM_W   = QUO_W + 1;

  // Transform datapath widths
  localparam int unsigned PRODW  = COEF_W + CAM_W;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned FLO_W  = ACC_W - COEF_FRAC;

  // Divisors per axis and the scaling of their reciprocals
  localparam longint unsigned DIV_DEN [NUM_AXES] = '{
    longint'(DEPTH_PER_M) * longint'(FX_TENTHS),
    longint'(DEPTH_PER_M) * longint'(FY_TENTHS),
    longint'(DEPTH_PER_M)
  };
  localparam int unsigned DIV_SHIFT [NUM_AXES] = '{30, 30, 17};

  // Cycles from an accepted item to its result strobe
  localparam int unsigned PIPE_LAT = 7;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_FIRST,
    CFG_ROT_SECOND,
    CFG_ROT_THIRD,
    CFG_SHIFT_X,
    CFG_SHIFT_Y,
    CFG_SHIFT_Z
  } cfg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0]   pixel_col;
    logic [ROW_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] color_red;
    logic [COLOR_W-1:0] color_green;
    logic [COLOR_W-1:0] color_blue;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_z;
    logic signed [COORD_W-1:0] world_y;
    logic [COLOR_W-1:0]        out_red;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_blue;
  } point_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Camera-space point between back-projection and transform
  typedef struct packed {
    logic                             valid;
    logic [NUM_AXES-1:0][CAM_W-1:0]   cam;
    rgb_t                             color;
  } cam_t;

  // Camera pose: rotation rows and translation
  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_REG_W-1:0] rot;
    logic [NUM_AXES-1:0][COORD_W-1:0]   shift;
  } pose_t;

  localparam logic [ROW_REG_W-1:0] ROT_ID_X = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_X);
  localparam logic [ROW_REG_W-1:0] ROT_ID_Y = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_Y);
  localparam logic [ROW_REG_W-1:0] ROT_ID_Z = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_Z);

  // Identity rotation, no translation
  localparam pose_t POSE_RESET = '{rot: {ROT_ID_Z, ROT_ID_Y, ROT_ID_X}, shift: '0};

endpackage

// ===== hdl/dpw_backproj.sv =====
// ----------------------------------------------------------------------------
// Pinhole back-projection pipeline
// Turns column, row and depth into camera X, Y, Z in signed Q6.16 over four stages,
// dividing by the constant intrinsics through reciprocal and remainder fix-up.
// ----------------------------------------------------------------------------
module dpw_backproj (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  dpw_pkg::pixel_t pixel_i,
  output dpw_pkg::cam_t   cam_o
);
  import dpw_pkg::*;

  localparam int unsigned TEN_W = OFS_W - 1;

  // Stage A: offsets and magnitude products
  logic [TEN_W-1:0]         col10, row10;
  logic signed [OFS_W-1:0]  off_x, off_y;
  logic [AMAG_W-1:0]        mag_x, mag_y;
  logic [PW-1:0]            a_p_d   [NUM_AXES];
  logic [NUM_AXES-1:0]      a_neg_d;
  rgb_t                     a_rgb_d;

  logic                     a_vld_q;
  logic [PW-1:0]            a_p_q   [NUM_AXES];
  logic [NUM_AXES-1:0]      a_neg_q;
  rgb_t                     a_rgb_q;

  // Stage B: trial quotient and rounded numerator
  logic [QUO_W-1:0]         b_quo_d [NUM_AXES];
  logic [NUM_W-1:0]         b_num_d [NUM_AXES];
  logic                     b_vld_q;
  logic [QUO_W-1:0]         b_quo_q [NUM_AXES];
  logic [NUM_W-1:0]         b_num_q [NUM_AXES];
  logic [NUM_AXES-1:0]      b_neg_q;
  rgb_t                     b_rgb_q;

  // Stage C: trial quotient times divisor
  logic [NUM_W-1:0]         c_back_d [NUM_AXES];
  logic                     c_vld_q;
  logic [QUO_W-1:0]         c_quo_q  [NUM_AXES];
  logic [NUM_W-1:0]         c_num_q  [NUM_AXES];
  logic [NUM_W-1:0]         c_back_q [NUM_AXES];
  logic [NUM_AXES-1:0]      c_neg_q;
  rgb_t                     c_rgb_q;

  // Stage D: corrected, signed camera coordinate
  logic [CAM_W-1:0]         d_cam_d [NUM_AXES];
  logic                     d_vld_q;
  logic [CAM_W-1:0]         d_cam_q [NUM_AXES];
  rgb_t                     d_rgb_q;

  // Offset from the principal point, magnitude times depth
  always_comb begin
    col10 = TEN_W'(pixel_i.pixel_col) * TEN_W'(TENTHS);
    row10 = TEN_W'(pixel_i.pixel_row) * TEN_W'(TENTHS);
    off_x = $signed({1'b0, col10}) - $signed(OFS_W'(CX_TENTHS));
    off_y = $signed({1'b0, row10}) - $signed(OFS_W'(CY_TENTHS));
    mag_x = off_x[OFS_W-1] ? AMAG_W'(-off_x) : AMAG_W'(off_x);
    mag_y = off_y[OFS_W-1] ? AMAG_W'(-off_y) : AMAG_W'(off_y);

    a_p_d[AXIS_X]   = PW'(mag_x) * PW'(pixel_i.depth_raw);
    a_p_d[AXIS_Y]   = PW'(mag_y) * PW'(pixel_i.depth_raw);
    a_p_d[AXIS_Z]   = PW'(pixel_i.depth_raw);
    a_neg_d         = '0;
    a_neg_d[AXIS_X] = off_x[OFS_W-1];
    a_neg_d[AXIS_Y] = off_y[OFS_W-1];

    a_rgb_d.red   = pixel_i.color_red;
    a_rgb_d.green = pixel_i.color_green;
    a_rgb_d.blue  = pixel_i.color_blue;
  end

  // Per-axis constant division: round(p * 2^16 / den), ties away from zero
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_div
    localparam longint unsigned DEN   = DIV_DEN[ax];
    localparam int unsigned     SHIFT = DIV_SHIFT[ax];
    localparam longint unsigned RECIP = (64'd1 << (SHIFT + FRAC_SHIFT)) / DEN;
    localparam longint unsigned HALF  = DEN / 2;

    logic [TRIAL_W-1:0] trial;
    logic [NUM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo_fix;

    // Trial quotient undershoots the exact one by at most one
    assign trial = (TRIAL_W'(a_p_q[ax]) * TRIAL_W'(RECIP_W'(RECIP)))
                 + (TRIAL_W'(1) << (SHIFT - 1));
    assign b_quo_d[ax] = QUO_W'(trial >> SHIFT);
    assign b_num_d[ax] = (NUM_W'(a_p_q[ax]) << FRAC_SHIFT) + NUM_W'(HALF);

    assign c_back_d[ax] = NUM_W'(b_quo_q[ax]) * NUM_W'(DEN);

    // Bump the quotient when the remainder still holds a whole divisor
    assign rem         = c_num_q[ax] - c_back_q[ax];
    assign quo_fix     = c_quo_q[ax] + QUO_W'(rem >= NUM_W'(DEN));
    assign d_cam_d[ax] = c_neg_q[ax] ? CAM_W'(-$signed({1'b0, quo_fix}))
                                     : CAM_W'({1'b0, quo_fix});
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    a_p_q    <= a_p_d;
    a_neg_q  <= a_neg_d;
    a_rgb_q  <= a_rgb_d;
    b_quo_q  <= b_quo_d;
    b_num_q  <= b_num_d;
    b_neg_q  <= a_neg_q;
    b_rgb_q  <= a_rgb_q;
    c_quo_q  <= b_quo_q;
    c_num_q  <= b_num_q;
    c_back_q <= c_back_d;
    c_neg_q  <= b_neg_q;
    c_rgb_q  <= b_rgb_q;
    d_cam_q  <= d_cam_d;
    d_rgb_q  <= c_rgb_q;
  end

  // Pack the camera-space item
  always_comb begin
    cam_o.valid = d_vld_q;
    cam_o.color = d_rgb_q;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      cam_o.cam[ax] = d_cam_q[ax];
    end
  end

endmodule

// ===== hdl/dpw_xform.sv =====
// ----------------------------------------------------------------------------
// Pose transform pipeline
// Rotates and translates a camera point into world space over three stages,
// rounds to Q16.16 and saturates; the last stage is the output register.
// ----------------------------------------------------------------------------
module dpw_xform (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpw_pkg::cam_t   cam_i,
  input  dpw_pkg::pose_t  pose_i,
  output logic            done_o,
  output dpw_pkg::point_t point_o
);
  import dpw_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [COORD_W-1:0]      SAT_MIN  = COORD_W'(1) << (COORD_W - 1);
  localparam logic [COORD_W-1:0]      SAT_MAX  = ~SAT_MIN;

  // Stage E: coefficient products
  logic signed [PRODW-1:0] e_prod_d [NUM_AXES][NUM_AXES];
  logic                    e_vld_q;
  logic signed [PRODW-1:0] e_prod_q [NUM_AXES][NUM_AXES];
  rgb_t                    e_rgb_q;

  // Stage F: row sums with translation and rounding bias
  logic signed [ACC_W-1:0] f_acc_d [NUM_AXES];
  logic                    f_vld_q;
  logic signed [ACC_W-1:0] f_acc_q [NUM_AXES];
  rgb_t                    f_rgb_q;

  // Stage G: output register
  logic [COORD_W-1:0]      coord [NUM_AXES];
  point_t                  point_d;
  logic                    done_q;
  point_t                  point_q;

  // Multiply every coefficient by its camera coordinate
  always_comb begin
    logic signed [PRODW-1:0] coef_ext;
    logic signed [PRODW-1:0] cam_ext;
    coef_ext = '0;
    cam_ext  = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        coef_ext       = PRODW'($signed(pose_i.rot[r][COEF_W*c +: COEF_W]));
        cam_ext        = PRODW'($signed(cam_i.cam[c]));
        e_prod_d[r][c] = coef_ext * cam_ext;
      end
    end
  end

  // Sum each row, add the scaled translation and half an output LSB
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      f_acc_d[r] = (ACC_W'($signed(pose_i.shift[r])) <<< COEF_FRAC) + RND_HALF;
      for (int c = 0; c < NUM_AXES; c++) begin
        f_acc_d[r] = f_acc_d[r] + ACC_W'(e_prod_q[r][c]);
      end
    end
  end

  // Floor to Q16.16 and clamp to the 32-bit range
  always_comb begin
    logic signed [FLO_W-1:0] flo;
    logic [FLO_W-COORD_W:0]  top;
    flo = '0;
    top = '0;
    for (int r = 0; r < NUM_AXES; r++) begin
      flo = FLO_W'(f_acc_q[r] >>> COEF_FRAC);
      top = flo[FLO_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
        coord[r] = flo[COORD_W-1:0];
      end else begin
        coord[r] = flo[FLO_W-1] ? SAT_MIN : SAT_MAX;
      end
    end
    point_d.world_x   = coord[AXIS_X];
    point_d.world_y   = coord[AXIS_Y];
    point_d.world_z   = coord[AXIS_Z];
    point_d.out_red   = f_rgb_q.red;
    point_d.out_green = f_rgb_q.green;
    point_d.out_blue  = f_rgb_q.blue;
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      e_vld_q <= cam_i.valid;
      f_vld_q <= e_vld_q;
      done_q  <= f_vld_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    e_prod_q <= e_prod_d;
    e_rgb_q  <= cam_i.color;
    f_acc_q  <= f_acc_d;
    f_rgb_q  <= e_rgb_q;
    point_q  <= point_d;
  end

  assign done_o  = done_q;
  assign point_o = point_q;

endmodule

// ===== hdl/depth_pixel_to_world_point.sv =====
// ----------------------------------------------------------------------------
// Depth pixel to world point
// Back-projects depth pixels through fixed pinhole intrinsics and the
// configured camera pose into saturated Q16.16 world points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive pixel_i and raise start; the item is taken at each
//   rising edge where start is high and busy is low. busy stays low, so one
//   pixel can be taken in every cycle.
//   Result channel: done_o is high for exactly one cycle with the point on
//   point_o; the receiver must take it then, it cannot stall the block.
//   Pixels with zero depth or outside IMAGE_WIDTH x IMAGE_HEIGHT give no
//   result and do not delay the other items.
//   Pipeline: seven register stages, four of back-projection (offset
//   product, reciprocal multiply, back-multiply, remainder fix-up) and three
//   of transform (products, row sum, round and clamp). Throughput: one item
//   per cycle.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
//   clock edge; write only while no item is in flight.
//   Reset: clears the pipeline valid bits and loads the identity pose with
//   no translation; there is no clearing pass.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  dpw_pkg::pixel_t                pixel_i,
  output logic                           done_o,
  output dpw_pkg::point_t                point_o,
  input  logic                           cfg_we_i,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpw_pkg::*;

`include "depth_pixel_to_world_point_assert.svh"

  pose_t pose_q;
  logic  keep;
  cam_t  cam;

  // The pipeline never holds off an item
  assign busy = 1'b0;

  // Keep only measured pixels that lie inside the image
  assign keep = start && !busy
             && (pixel_i.depth_raw != '0)
             && (DIM_W'(pixel_i.pixel_col) < DIM_W'(IMAGE_WIDTH))
             && (DIM_W'(pixel_i.pixel_row) < DIM_W'(IMAGE_HEIGHT));

  // Pose registers; unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_q <= POSE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROT_FIRST:  pose_q.rot[AXIS_X]   <= cfg_data_i;
        CFG_ROT_SECOND: pose_q.rot[AXIS_Y]   <= cfg_data_i;
        CFG_ROT_THIRD:  pose_q.rot[AXIS_Z]   <= cfg_data_i;
        CFG_SHIFT_X:    pose_q.shift[AXIS_X] <= cfg_data_i[COORD_W-1:0];
        CFG_SHIFT_Y:    pose_q.shift[AXIS_Y] <= cfg_data_i[COORD_W-1:0];
        CFG_SHIFT_Z:    pose_q.shift[AXIS_Z] <= cfg_data_i[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpw_backproj u_backproj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (keep),
    .pixel_i (pixel_i),
    .cam_o   (cam)
  );

  dpw_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cam_i   (cam),
    .pose_i  (pose_q),
    .done_o  (done_o),
    .point_o (point_o)
  );

  // Every kept item strobes out after the pipeline latency
  `DPW_ASSERT_LAT(a_kept_item_strobes, clk_i, rst_ni, keep, PIPE_LAT, done_o, "kept item lost")

  // No strobe without a kept item at the matching cycle
  `DPW_ASSERT_IMP(a_strobe_has_item, clk_i, rst_ni, done_o, $past(keep, PIPE_LAT), "result invented")

  // Red and blue colour bytes travel with their item
  `DPW_ASSERT_IMP(a_colour_follows, clk_i, rst_ni, done_o, (point_o.out_red == $past(pixel_i.color_red, PIPE_LAT)) && (point_o.out_blue == $past(pixel_i.color_blue, PIPE_LAT)), "colour misaligned")

endmodule

// ===== bench/depth_pixel_to_world_point_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth back-projection point checker
// Watches the pose writes, the pixel channel and the point channel, predicts
// each world point in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module dpw_point_checker #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  dpw_pkg::pixel_t                pixel_i,
  input  logic                           done_i,
  input  dpw_pkg::point_t                point_i,
  input  logic                           cfg_we_i,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);
  import dpw_pkg::*;

  pose_t  pose;
  point_t expected_points [$];
  point_t predicted;
  point_t oldest;
  int     fail_cnt;

  // Divide rounding to nearest, ties away from zero (divisor positive)
  function automatic longint round_div(input longint n, input longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  // One world coordinate: rotation row dot camera point plus translation,
  // rounded from 30 to 16 fraction bits and clamped to 32 bits
  function automatic logic [COORD_W-1:0] world_axis(input logic [ROW_REG_W-1:0] row,
                                                    input logic [COORD_W-1:0] shift,
                                                    input longint cam [NUM_AXES]);
    longint acc;
    longint q;
    longint hi;
    longint lo;
    int     j;
    hi  = (longint'(1) << 31) - 1;
    lo  = -(longint'(1) << 31);
    acc = 0;
    for (j = 0; j < NUM_AXES; j++) begin
      acc += longint'($signed(row[COEF_W*j +: COEF_W])) * cam[j];
    end
    acc += longint'($signed(shift)) * (longint'(1) << COEF_FRAC);
    acc += longint'(1) << (COEF_FRAC - 1);
    q = acc >>> COEF_FRAC;
    if (q > hi) begin
      q = hi;
    end
    if (q < lo) begin
      q = lo;
    end
    return q[COORD_W-1:0];
  endfunction

  // Predict the point of one pixel; return 0 where the pixel gives none
  function automatic bit backproject(input pixel_t px, input pose_t ps, output point_t pt);
    longint cam [NUM_AXES];
    longint depth;
    longint scale;
    longint ofs_x;
    longint ofs_y;
    pt = '0;
    if (px.depth_raw == '0) begin
      return 1'b0;
    end
    if (px.pixel_col >= IMAGE_WIDTH || px.pixel_row >= IMAGE_HEIGHT) begin
      return 1'b0;
    end
    depth = longint'(px.depth_raw);
    scale = longint'(1) << FRAC_SHIFT;
    ofs_x = longint'(TENTHS) * longint'(px.pixel_col) - longint'(CX_TENTHS);
    ofs_y = longint'(TENTHS) * longint'(px.pixel_row) - longint'(CY_TENTHS);
    cam[AXIS_Z] = round_div(depth * scale, longint'(DEPTH_PER_M));
    cam[AXIS_X] = round_div(ofs_x * depth * scale,
                            longint'(DEPTH_PER_M) * longint'(FX_TENTHS));
    cam[AXIS_Y] = round_div(ofs_y * depth * scale,
                            longint'(DEPTH_PER_M) * longint'(FY_TENTHS));
    pt.world_x   = world_axis(ps.rot[AXIS_X], ps.shift[AXIS_X], cam);
    pt.world_z   = world_axis(ps.rot[AXIS_Z], ps.shift[AXIS_Z], cam);
    pt.world_y   = world_axis(ps.rot[AXIS_Y], ps.shift[AXIS_Y], cam);
    pt.out_red   = px.color_red;
    pt.out_green = px.color_green;
    pt.out_blue  = px.color_blue;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Track the pose, queue predictions and compare strobed points
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose.rot[AXIS_X]   = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_X);
      pose.rot[AXIS_Y]   = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_Y);
      pose.rot[AXIS_Z]   = ROW_REG_W'(1) << (COEF_FRAC + COEF_W * AXIS_Z);
      pose.shift         = '0;
      expected_points.delete();
      fail_cnt           = 0;
      errors_o          <= 0;
      pending_o         <= 0;
    end else begin
      // compare a strobed point with the oldest prediction
      if (done_i) begin
        if (expected_points.size() == 0) begin
          $error("point strobed with none expected: %h", point_i);
          fail_cnt++;
        end else begin
          oldest = expected_points.pop_front();
          check_field("world_x", oldest.world_x, point_i.world_x);
          check_field("world_z", oldest.world_z, point_i.world_z);
          check_field("world_y", oldest.world_y, point_i.world_y);
          check_field("out_red", COORD_W'(oldest.out_red), COORD_W'(point_i.out_red));
          check_field("out_green", COORD_W'(oldest.out_green), COORD_W'(point_i.out_green));
          check_field("out_blue", COORD_W'(oldest.out_blue), COORD_W'(point_i.out_blue));
        end
      end
      // predict each accepted item
      if (start_i && !busy_i) begin
        if (backproject(pixel_i, pose, predicted)) begin
          expected_points = {expected_points, predicted};
        end
      end
      // follow pose writes; unknown indices change nothing
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROT_FIRST:  pose.rot[AXIS_X]   = cfg_data_i[ROW_REG_W-1:0];
          CFG_ROT_SECOND: pose.rot[AXIS_Y]   = cfg_data_i[ROW_REG_W-1:0];
          CFG_ROT_THIRD:  pose.rot[AXIS_Z]   = cfg_data_i[ROW_REG_W-1:0];
          CFG_SHIFT_X:    pose.shift[AXIS_X] = cfg_data_i[COORD_W-1:0];
          CFG_SHIFT_Y:    pose.shift[AXIS_Y] = cfg_data_i[COORD_W-1:0];
          CFG_SHIFT_Z:    pose.shift[AXIS_Z] = cfg_data_i[COORD_W-1:0];
          default: ;
        endcase
      end
      errors_o  <= fail_cnt;
      pending_o <= expected_points.size();
    end
  end

endmodule

// ===== bench/tb_depth_pixel_to_world_point.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pixel to world point testbench
// Streams directed and random depth pixels through the block under several
// camera poses, with and without sender gaps; the checker predicts and
// compares every world point.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_world_point;
  import dpw_pkg::*;

  localparam int unsigned IMG_W          = 640;
  localparam int unsigned IMG_H          = 480;
  localparam int unsigned BLOCKS         = 6;
  localparam int unsigned ITEMS_PER_BLK  = 215;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_SHIFT_Z + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pixel_t                pixel;
  logic                  done;
  point_t                point;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    cycle_cnt;
  int                    idle_pct;

  depth_pixel_to_world_point #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel),
    .done_o     (done),
    .point_o    (point),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  dpw_point_checker #(
    .IMAGE_WIDTH  (IMG_W),
    .IMAGE_HEIGHT (IMG_H)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .pixel_i    (pixel),
    .done_i     (done),
    .point_i    (point),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abandon the run at the cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_depth_pixel_to_world_point: errors");
      $finish;
    end
  end

  function automatic pixel_t mk_pixel(input int col, input int row, input int depth,
                                      input int red, input int green, input int blue);
    pixel_t p;
    p.pixel_col   = COL_W'(col);
    p.pixel_row   = ROW_W'(row);
    p.depth_raw   = DEPTH_W'(depth);
    p.color_red   = COLOR_W'(red);
    p.color_green = COLOR_W'(green);
    p.color_blue  = COLOR_W'(blue);
    return p;
  endfunction

  // Mostly valid pixels; some with no depth, some off the image
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     pick;
    pick          = $urandom_range(99);
    p.pixel_col   = COL_W'($urandom_range(IMG_W - 1));
    p.pixel_row   = ROW_W'($urandom_range(IMG_H - 1));
    p.color_red   = COLOR_W'($urandom);
    p.color_green = COLOR_W'($urandom);
    p.color_blue  = COLOR_W'($urandom);
    case ($urandom_range(3))
      0:       p.depth_raw = DEPTH_W'($urandom_range(1, 16));
      1:       p.depth_raw = DEPTH_W'($urandom_range(60000, 65535));
      default: p.depth_raw = DEPTH_W'($urandom_range(1, 65535));
    endcase
    if (pick < 6) begin
      p.depth_raw = '0;
    end else if (pick < 10) begin
      p.pixel_col = COL_W'($urandom_range(IMG_W, (1 << COL_W) - 1));
    end else if (pick < 14) begin
      p.pixel_row = ROW_W'($urandom_range(IMG_H, (1 << ROW_W) - 1));
    end
    return p;
  endfunction

  function automatic logic [ROW_REG_W-1:0] pack_row(input logic [COEF_W-1:0] c0,
                                                    input logic [COEF_W-1:0] c1,
                                                    input logic [COEF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    int v;
    v = $urandom_range(2 << COEF_FRAC);
    return COEF_W'(v - (1 << COEF_FRAC));
  endfunction

  // Offer one item, idling first at the current rate; return once taken
  task automatic send_pixel(input pixel_t p);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    pixel <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop offering and let every item in flight leave the pipeline
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Write a whole pose, with junk above the shift width and spare indices
  task automatic load_pose(input logic [ROW_REG_W-1:0] r_first,
                           input logic [ROW_REG_W-1:0] r_second,
                           input logic [ROW_REG_W-1:0] r_third,
                           input logic [COORD_W-1:0] sx,
                           input logic [COORD_W-1:0] sy,
                           input logic [COORD_W-1:0] sz);
    cfg_put(CFG_ROT_FIRST, r_first);
    cfg_put(CFG_IDX_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
    cfg_put(CFG_ROT_SECOND, r_second);
    cfg_put(CFG_ROT_THIRD, r_third);
    cfg_put(CFG_SHIFT_X, {16'($urandom), sx});
    cfg_put(CFG_SHIFT_Y, {16'($urandom), sy});
    cfg_put(CFG_IDX_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
    cfg_put(CFG_SHIFT_Z, {16'($urandom), sz});
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    pixel     <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_data  <= '0;
    cycle_cnt <= 0;
    idle_pct   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed pixels under the reset pose: corners, centre, edges, no depth
    send_pixel(mk_pixel(0, 0, 1, 0, 0, 0));
    send_pixel(mk_pixel(IMG_W - 1, IMG_H - 1, 65535, 255, 255, 255));
    send_pixel(mk_pixel(0, IMG_H - 1, 65535, 170, 85, 170));
    send_pixel(mk_pixel(IMG_W - 1, 0, 65535, 85, 170, 85));
    send_pixel(mk_pixel(320, 256, 5000, 1, 2, 3));
    send_pixel(mk_pixel(318, 255, 2500, 128, 127, 64));
    send_pixel(mk_pixel(319, 256, 1, 255, 0, 255));
    send_pixel(mk_pixel(100, 200, 0, 11, 22, 33));
    send_pixel(mk_pixel(1023, 511, 0, 255, 255, 255));
    send_pixel(mk_pixel(IMG_W, 0, 1000, 9, 9, 9));
    send_pixel(mk_pixel(0, IMG_H, 1000, 7, 7, 7));
    send_pixel(mk_pixel(1023, 100, 65535, 200, 100, 50));
    send_pixel(mk_pixel(100, 511, 65535, 50, 100, 200));
    send_pixel(mk_pixel(IMG_W - 1, IMG_H - 1, 1, 0, 255, 0));
    send_pixel(mk_pixel(0, 0, 65535, 255, 0, 0));
    send_pixel(mk_pixel(512, 256, 32768, 0, 0, 255));
    send_pixel(mk_pixel(511, 255, 32767, 16, 32, 48));
    send_pixel(mk_pixel(200, 300, 3, 240, 15, 60));
    send_pixel(mk_pixel(600, 50, 40000, 3, 6, 9));
    send_pixel(mk_pixel(10, 470, 12345, 99, 199, 249));
    drain();

    // random pixels, one pose per block
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk)
        0: load_pose(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        1: load_pose(pack_row(16'h8000, 16'h8000, 16'h8000),
                     pack_row(16'h8000, 16'h8000, 16'h8000),
                     pack_row(16'h8000, 16'h8000, 16'h8000),
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        2: load_pose(ROW_REG_W'({$urandom, $urandom}), ROW_REG_W'({$urandom, $urandom}),
                     ROW_REG_W'({$urandom, $urandom}), $urandom, $urandom, $urandom);
        // quarter turn about z with a small offset
        3: load_pose(pack_row(16'h0000, 16'hC000, 16'h0000),
                     pack_row(16'h4000, 16'h0000, 16'h0000),
                     pack_row(16'h0000, 16'h0000, 16'h4000),
                     32'($urandom_range(20 << 16)) - 32'(10 << 16),
                     32'($urandom_range(20 << 16)) - 32'(10 << 16),
                     32'($urandom_range(20 << 16)) - 32'(10 << 16));
        4: load_pose(pack_row(rand_coef(), rand_coef(), rand_coef()),
                     pack_row(rand_coef(), rand_coef(), rand_coef()),
                     pack_row(rand_coef(), rand_coef(), rand_coef()),
                     32'($urandom_range(200 << 16)) - 32'(100 << 16),
                     32'($urandom_range(200 << 16)) - 32'(100 << 16),
                     32'($urandom_range(200 << 16)) - 32'(100 << 16));
        default: load_pose('0, '0, '0, $urandom, $urandom, $urandom);
      endcase
      idle_pct = (blk < 2) ? 12 : (blk < 4) ? 62 : 0;
      repeat (ITEMS_PER_BLK) send_pixel(rand_pixel());
      drain();
    end

    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_depth_pixel_to_world_point: clean");
    end else begin
      $display("tb_depth_pixel_to_world_point: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dpw_pkg.sv
hdl/dpw_backproj.sv
hdl/dpw_xform.sv
hdl/depth_pixel_to_world_point.sv
bench/depth_pixel_to_world_point_checker.sv
bench/tb_depth_pixel_to_world_point.sv
